>>> rtl/utf8_byte_stream_decoder_top_macros.svh
`ifndef UTF8_BYTE_STREAM_DECODER_TOP_MACROS_SVH
`define UTF8_BYTE_STREAM_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define U8D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define U8D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/u8dec_pkg.sv
package u8dec_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned OWED_W  = 2;
  localparam int unsigned CONT_W  = 6;

  // Lead byte class limits.
  localparam logic [BYTE_W-1:0] LEAD_1B_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD_2B_LIMIT = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_3B_LIMIT = 8'hF0;

  // Payload masks.
  localparam logic [BYTE_W-1:0] LEAD_2B_MASK = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD_3B_MASK = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD_4B_MASK = 8'h07;
  localparam logic [BYTE_W-1:0] CONT_MASK    = 8'h3F;

  // Continuation bytes still expected.
  localparam logic [OWED_W-1:0] OWED_NONE  = 2'd0;
  localparam logic [OWED_W-1:0] OWED_ONE   = 2'd1;
  localparam logic [OWED_W-1:0] OWED_TWO   = 2'd2;
  localparam logic [OWED_W-1:0] OWED_THREE = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_text;
  } byte_item_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            truncated;
    logic            last;
  } char_item_t;

endpackage

>>> rtl/u8dec_byte_if.sv
interface u8dec_byte_if;
  logic                          valid;
  logic                          ready;
  logic [u8dec_pkg::BYTE_W-1:0]  data_byte;
  logic                          end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

>>> rtl/u8dec_char_if.sv
interface u8dec_char_if;
  logic                        valid;
  logic                        ready;
  logic [u8dec_pkg::CP_W-1:0]  code_point;
  logic                        truncated;
  logic                        last;

  modport source (output valid, output code_point, output truncated, output last,
                  input ready);
  modport sink   (input valid, input code_point, input truncated, input last,
                  output ready);
endinterface

>>> rtl/utf8_byte_stream_decoder_top.sv
// UTF-8 byte stream decoder.
// byte_i takes one raw byte of text per request, with end_of_text set on the
// final byte of the text. char_o delivers one code point per finished
// sequence, with truncated set when the text ended inside a sequence (the
// missing continuation bytes count as zero) and last set on the final code
// point of the text. Other bytes give no request unless they end the text.
// Path: an accepted byte lands in the input register and is decoded
// from there into the result register, which shows its code point.
// Throughput: one byte per cycle while char_o is not held. Each byte
// costs a shift and OR on the partial value between the input register
// and the result register.
// Reset: both registers empty, partial value and owed count cleared; the
// next byte is a lead byte.
// Stall: while char_o is held, the result register keeps its request and
// the input register holds one more byte; byte_i drops ready only when both
// are full. No byte is lost or repeated.
module utf8_byte_stream_decoder_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  u8dec_byte_if.sink   byte_i,
  u8dec_char_if.source char_o
);
  import u8dec_pkg::*;
  `include "utf8_byte_stream_decoder_top_macros.svh"

  // Input register.
  logic        in_vld_q, in_vld_d;
  byte_item_t  in_q, in_d;

  // Decoder state.
  logic [CP_W-1:0]   part_q, part_d;
  logic [OWED_W-1:0] owed_q, owed_d;

  // Result register.
  logic        out_vld_q, out_vld_d;
  char_item_t  out_q, out_d;

  logic        out_free;
  logic        dec_fire;
  logic        has_res;
  char_item_t  res;
  logic [CP_W-1:0]   part_nx;
  logic [OWED_W-1:0] owed_nx;
  logic [CP_W-1:0]   cont_val;

  // The result register frees when empty or taken this cycle.
  assign out_free     = !out_vld_q || char_o.ready;
  assign dec_fire     = in_vld_q && out_free;
  assign byte_i.ready = !in_vld_q || out_free;

  assign cont_val = {part_q[CP_W-CONT_W-1:0], in_q.data_byte[CONT_W-1:0]};

  // Decode one byte: classify a lead or shift in a continuation.
  always_comb begin
    has_res = 1'b0;
    res     = '0;
    part_nx = part_q;
    owed_nx = owed_q;
    if (owed_q == OWED_NONE) begin
      if (in_q.data_byte < LEAD_1B_LIMIT) begin
        has_res = 1'b1;
        res     = '{code_point: CP_W'(in_q.data_byte), truncated: 1'b0,
                    last: in_q.end_of_text};
      end else if (in_q.data_byte < LEAD_2B_LIMIT) begin
        part_nx = CP_W'(in_q.data_byte & LEAD_2B_MASK);
        owed_nx = OWED_ONE;
      end else if (in_q.data_byte < LEAD_3B_LIMIT) begin
        part_nx = CP_W'(in_q.data_byte & LEAD_3B_MASK);
        owed_nx = OWED_TWO;
      end else begin
        part_nx = CP_W'(in_q.data_byte & LEAD_4B_MASK);
        owed_nx = OWED_THREE;
      end
    end else begin
      owed_nx = owed_q - OWED_ONE;
      part_nx = cont_val;
      if (owed_nx == OWED_NONE) begin
        has_res = 1'b1;
        res     = '{code_point: cont_val, truncated: 1'b0, last: in_q.end_of_text};
        part_nx = '0;
      end
    end
    // Text ends inside a sequence: zero-fill the missing bytes and close.
    if (!has_res && in_q.end_of_text) begin
      has_res = 1'b1;
      res.truncated = 1'b1;
      res.last      = 1'b1;
      case (owed_nx)
        OWED_ONE:   res.code_point = part_nx << CONT_W;
        OWED_TWO:   res.code_point = part_nx << (2 * CONT_W);
        OWED_THREE: res.code_point = part_nx << (3 * CONT_W);
        default:    res.code_point = part_nx;
      endcase
      part_nx = '0;
      owed_nx = OWED_NONE;
    end
  end

  always_comb begin
    in_vld_d  = in_vld_q;
    in_d      = in_q;
    part_d    = part_q;
    owed_d    = owed_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (dec_fire) begin
      in_vld_d  = 1'b0;
      part_d    = part_nx;
      owed_d    = owed_nx;
      out_vld_d = has_res;
      if (has_res) begin
        out_d = res;
      end
    end else if (char_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (byte_i.valid && byte_i.ready) begin
      in_vld_d = 1'b1;
      in_d     = '{data_byte: byte_i.data_byte, end_of_text: byte_i.end_of_text};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      part_q    <= '0;
      owed_q    <= OWED_NONE;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      part_q    <= part_d;
      owed_q    <= owed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign char_o.valid      = out_vld_q;
  assign char_o.code_point = out_q.code_point;
  assign char_o.truncated  = out_q.truncated;
  assign char_o.last       = out_q.last;

  `U8D_ASSERT_NOW(a_trunc_is_last, out_vld_q && out_q.truncated, out_q.last,
                  "truncated result without last")
  `U8D_ASSERT_NEXT(a_eot_closes, dec_fire && in_q.end_of_text,
                   owed_q == OWED_NONE && part_q == '0 && out_vld_q && out_q.last,
                   "end of text left a sequence open")
  `U8D_ASSERT_NEXT(a_hold_byte, in_vld_q && !out_free, in_vld_q && $stable(in_q),
                   "stalled input byte lost")
  `U8D_ASSERT_NEXT(a_ascii_pass,
                   dec_fire && owed_q == OWED_NONE && !in_q.data_byte[BYTE_W-1],
                   out_vld_q && out_q.code_point == CP_W'($past(in_q.data_byte)),
                   "ASCII byte not passed through")
endmodule
